FILE: hw/rtl/acs_pkg.sv
// shared types, constants and helpers for the alignment column scorer
// no dependencies; used by every module of the block
package acs_pkg;

    localparam int SCORE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int SYM_WIDTH   = 8;
    localparam int COST_WIDTH  = 8;

    localparam logic [SYM_WIDTH-1:0] GAP_SYMBOL = 8'h2D;

    localparam logic signed [COST_WIDTH-1:0] AT_MATCH_RESET = 8'sd4;
    localparam logic signed [COST_WIDTH-1:0] GC_MATCH_RESET = 8'sd6;
    localparam logic signed [COST_WIDTH-1:0] MISMATCH_RESET = -8'sd4;
    localparam logic signed [COST_WIDTH-1:0] GAP_COST_RESET = -8'sd12;

    typedef enum logic [1:0] {
        CFG_AT_MATCH = 2'd0,
        CFG_GC_MATCH = 2'd1,
        CFG_MISMATCH = 2'd2,
        CFG_GAP_COST = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        BC_NONE = 2'd0,
        BC_AT   = 2'd1,
        BC_GC   = 2'd2
    } base_class_t;

    typedef struct packed {
        logic                          is_gap;
        logic                          add_en;
        logic signed [COST_WIDTH-1:0]  delta;
    } column_info_t;

    typedef struct packed {
        logic signed [SCORE_WIDTH-1:0] score;
        logic                          saturated;
    } acc_result_t;

    // u counts as t; lower and upper case share a class
    function automatic base_class_t base_class(input logic [SYM_WIDTH-1:0] c);
        base_class_t cls;
        case (c)
            8'h41, 8'h61, 8'h54, 8'h74, 8'h55, 8'h75: cls = BC_AT;
            8'h47, 8'h67, 8'h43, 8'h63:               cls = BC_GC;
            default:                                  cls = BC_NONE;
        endcase
        return cls;
    endfunction

    // low output bits of the score, sign extended when the score is narrower
    function automatic logic signed [OUT_WIDTH-1:0] score_to_out(
        input logic signed [SCORE_WIDTH-1:0] s
    );
        logic signed [63:0] w;
        w = 64'(s);
        return w[OUT_WIDTH-1:0];
    endfunction

endpackage

FILE: hw/rtl/acs_column_delta.sv
// per-column classification: gap detect and match/mismatch delta select
// depends on acs_pkg
module acs_column_delta (
    input  logic [acs_pkg::SYM_WIDTH-1:0]          target_symbol,
    input  logic [acs_pkg::SYM_WIDTH-1:0]          query_symbol,
    input  logic signed [acs_pkg::COST_WIDTH-1:0]  at_match_score,
    input  logic signed [acs_pkg::COST_WIDTH-1:0]  gc_match_score,
    input  logic signed [acs_pkg::COST_WIDTH-1:0]  mismatch_cost,
    output acs_pkg::column_info_t                  col
);

    acs_pkg::base_class_t cls;

    assign cls = acs_pkg::base_class(target_symbol);

    always_comb begin
        col.is_gap = (target_symbol == acs_pkg::GAP_SYMBOL) ||
                     (query_symbol == acs_pkg::GAP_SYMBOL);
        col.add_en = 1'b0;
        col.delta  = mismatch_cost;
        if (target_symbol != query_symbol) begin
            col.add_en = 1'b1;
        end else begin
            case (cls)
                acs_pkg::BC_AT: begin
                    col.add_en = 1'b1;
                    col.delta  = at_match_score;
                end
                acs_pkg::BC_GC: begin
                    col.add_en = 1'b1;
                    col.delta  = gc_match_score;
                end
                default: begin
                    // equal non-base bytes add nothing
                    col.add_en = 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/acs_accum.sv
// running score state: gap run tracking and saturating accumulate
// depends on acs_pkg
module acs_accum (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   advance,
    input  logic                                   last_column,
    input  acs_pkg::column_info_t                  col,
    input  logic signed [acs_pkg::COST_WIDTH-1:0]  gap_cost,
    output acs_pkg::acc_result_t                   result
);

    localparam int SW = acs_pkg::SCORE_WIDTH;
    localparam int CW = acs_pkg::COST_WIDTH;

    logic signed [SW-1:0] score_reg, score_next;
    logic                 in_gap_reg, in_gap_next;
    logic                 ext_reg, ext_next;
    logic                 sat_reg, sat_next;

    logic                 charge;
    logic signed [CW-1:0] delta;
    logic        [SW:0]   sum;
    logic signed [SW-1:0] new_score;
    logic                 ovf;

    always_comb begin
        in_gap_next = in_gap_reg;
        ext_next    = ext_reg;
        charge      = 1'b0;
        delta       = col.delta;
        if (col.is_gap) begin
            delta = gap_cost;
            if (!in_gap_reg) begin
                in_gap_next = 1'b1;
                ext_next    = 1'b0;
                charge      = 1'b1;
            end else if (!ext_reg) begin
                ext_next = 1'b1;
                charge   = 1'b1;
            end
        end else begin
            in_gap_next = 1'b0;
            charge      = col.add_en;
        end
        // gap tracking starts over after the last column
        if (last_column) begin
            in_gap_next = 1'b0;
            ext_next    = 1'b0;
        end
    end

    // one guard bit catches overflow of either sign
    assign sum = {score_reg[SW-1], score_reg} + {{(SW-CW+1){delta[CW-1]}}, delta};
    assign ovf = charge && (sum[SW] != sum[SW-1]);

    always_comb begin
        if (!charge) begin
            new_score = score_reg;
        end else if (ovf) begin
            new_score = sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            new_score = sum[SW-1:0];
        end
    end

    assign result.score     = new_score;
    assign result.saturated = sat_reg || ovf;

    always_comb begin
        score_next = new_score;
        sat_next   = sat_reg || ovf;
        if (last_column) begin
            score_next = '0;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_reg  <= '0;
            in_gap_reg <= 1'b0;
            ext_reg    <= 1'b0;
            sat_reg    <= 1'b0;
        end else if (advance) begin
            score_reg  <= score_next;
            in_gap_reg <= in_gap_next;
            ext_reg    <= ext_next;
            sat_reg    <= sat_next;
        end
    end

endmodule

FILE: hw/rtl/alignment_column_scorer.sv
// alignment_column_scorer top: one item per cycle unless stalled; result on the last column
// items are scored from the input stage register; the result stage registers the score
// throughput: one item per cycle, set by the accumulate loop, unless a last column is held
// reset (aresetn, synchronous, active low): scores 4/6/-4/-12, running state cleared
// depends on acs_pkg, acs_column_delta, acs_accum
module alignment_column_scorer (
    input  logic                                      aclk,
    input  logic                                      aresetn,

    // configuration write port
    input  logic                                      cfg_wr_en,
    input  logic [1:0]                                cfg_index,
    input  logic [acs_pkg::COST_WIDTH-1:0]            cfg_data,

    // column items
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [acs_pkg::SYM_WIDTH-1:0]             s_target_symbol,
    input  logic [acs_pkg::SYM_WIDTH-1:0]             s_query_symbol,
    input  logic                                      s_last_column,

    // score items
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [acs_pkg::OUT_WIDTH-1:0]      m_alignment_score,
    output logic                                      m_score_saturated
);

    // scoring registers
    logic signed [acs_pkg::COST_WIDTH-1:0] at_match_reg;
    logic signed [acs_pkg::COST_WIDTH-1:0] gc_match_reg;
    logic signed [acs_pkg::COST_WIDTH-1:0] mismatch_reg;
    logic signed [acs_pkg::COST_WIDTH-1:0] gap_cost_reg;

    // input stage
    logic                            s1_valid_reg, s1_valid_next;
    logic [acs_pkg::SYM_WIDTH-1:0]   s1_target_reg;
    logic [acs_pkg::SYM_WIDTH-1:0]   s1_query_reg;
    logic                            s1_last_reg;

    // result stage
    logic                                  m_valid_reg, m_valid_next;
    logic signed [acs_pkg::OUT_WIDTH-1:0]  m_score_reg;
    logic                                  m_sat_reg;

    logic                   out_free;
    logic                   s1_adv;
    logic                   s_take;
    logic                   emit;
    acs_pkg::column_info_t  col;
    acs_pkg::acc_result_t   acc_res;

    // config writes, only while idle: a rule for the user, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_match_reg <= acs_pkg::AT_MATCH_RESET;
            gc_match_reg <= acs_pkg::GC_MATCH_RESET;
            mismatch_reg <= acs_pkg::MISMATCH_RESET;
            gap_cost_reg <= acs_pkg::GAP_COST_RESET;
        end else if (cfg_wr_en) begin
            unique case (acs_pkg::cfg_index_t'(cfg_index))
                acs_pkg::CFG_AT_MATCH: at_match_reg <= cfg_data;
                acs_pkg::CFG_GC_MATCH: gc_match_reg <= cfg_data;
                acs_pkg::CFG_MISMATCH: mismatch_reg <= cfg_data;
                acs_pkg::CFG_GAP_COST: gap_cost_reg <= cfg_data;
            endcase
        end
    end

    // non-last columns never need the result slot, so they always move on
    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || out_free);
    assign emit     = s1_adv && s1_last_reg;
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_take   = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_take) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // item payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            s1_target_reg <= s_target_symbol;
            s1_query_reg  <= s_query_symbol;
            s1_last_reg   <= s_last_column;
        end
    end

    acs_column_delta u_delta (
        .target_symbol  (s1_target_reg),
        .query_symbol   (s1_query_reg),
        .at_match_score (at_match_reg),
        .gc_match_score (gc_match_reg),
        .mismatch_cost  (mismatch_reg),
        .col            (col)
    );

    acs_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (s1_adv),
        .last_column (s1_last_reg),
        .col         (col),
        .gap_cost    (gap_cost_reg),
        .result      (acc_res)
    );

    // result register holds the score until it is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_score_reg <= acs_pkg::score_to_out(acc_res.score);
            m_sat_reg   <= acc_res.saturated;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_alignment_score = m_score_reg;
    assign m_score_saturated = m_sat_reg;

`ifndef ASSERT_OFF
    // a last column that moves on always shows up as a result
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg)
        else $error("last column advanced without a result");

    // a held column keeps its payload
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=>
            (s1_valid_reg && $stable(s1_target_reg) && $stable(s1_query_reg)
             && $stable(s1_last_reg)))
        else $error("stalled column lost or changed");

    // backpressure only comes from a waiting column
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && s1_last_reg && m_valid_reg && !m_ready))
        else $error("input stalled without cause");
`endif

endmodule

FILE: bench/testbench.sv
// self-checking bench for alignment_column_scorer: streams column items and checks score items
// predicts each alignment score in a small tally class; depends on acs_pkg and the scorer rtl
`timescale 1ns / 100ps

module testbench;

    // one expected score item per alignment
    typedef struct {
        logic signed [acs_pkg::OUT_WIDTH-1:0] score;
        logic                                 saturated;
    } final_score_t;

    // running alignment score, kept alongside the block, plus the queue of finished scores
    class alignment_tally;
        logic signed [acs_pkg::COST_WIDTH-1:0]  at_weight;
        logic signed [acs_pkg::COST_WIDTH-1:0]  gc_weight;
        logic signed [acs_pkg::COST_WIDTH-1:0]  mismatch_weight;
        logic signed [acs_pkg::COST_WIDTH-1:0]  gap_weight;
        logic signed [acs_pkg::SCORE_WIDTH-1:0] running;
        bit                                     in_gap;
        bit                                     extension_charged;
        bit                                     clamped;
        final_score_t                           expected_scores[$];
        int                                     failures;

        function new();
            at_weight       = acs_pkg::AT_MATCH_RESET;
            gc_weight       = acs_pkg::GC_MATCH_RESET;
            mismatch_weight = acs_pkg::MISMATCH_RESET;
            gap_weight      = acs_pkg::GAP_COST_RESET;
            failures        = 0;
            clear_alignment();
        endfunction

        function void clear_alignment();
            running           = '0;
            in_gap            = 1'b0;
            extension_charged = 1'b0;
            clamped           = 1'b0;
        endfunction

        function void set_weight(acs_pkg::cfg_index_t idx,
                                 logic [acs_pkg::COST_WIDTH-1:0] value);
            case (idx)
                acs_pkg::CFG_AT_MATCH: at_weight       = value;
                acs_pkg::CFG_GC_MATCH: gc_weight       = value;
                acs_pkg::CFG_MISMATCH: mismatch_weight = value;
                acs_pkg::CFG_GAP_COST: gap_weight      = value;
                default: ;
            endcase
        endfunction

        // saturating add at the score width
        function void accumulate(logic signed [acs_pkg::COST_WIDTH-1:0] delta);
            longint top;
            longint bottom;
            longint sum;
            top    = (longint'(1) <<< (acs_pkg::SCORE_WIDTH - 1)) - 1;
            bottom = -top - 1;
            sum    = longint'(running) + longint'(delta);
            if (sum > top) begin
                running = top[acs_pkg::SCORE_WIDTH-1:0];
                clamped = 1'b1;
            end else if (sum < bottom) begin
                running = bottom[acs_pkg::SCORE_WIDTH-1:0];
                clamped = 1'b1;
            end else begin
                running = sum[acs_pkg::SCORE_WIDTH-1:0];
            end
        endfunction

        function acs_pkg::base_class_t classify(logic [acs_pkg::SYM_WIDTH-1:0] c);
            case (c)
                "A", "a", "T", "t", "U", "u": return acs_pkg::BC_AT;
                "G", "g", "C", "c":           return acs_pkg::BC_GC;
                default:                      return acs_pkg::BC_NONE;
            endcase
        endfunction

        function void note_column(logic [acs_pkg::SYM_WIDTH-1:0] t,
                                  logic [acs_pkg::SYM_WIDTH-1:0] q, bit last);
            final_score_t       entry;
            logic signed [63:0] wide;
            if (t == acs_pkg::GAP_SYMBOL || q == acs_pkg::GAP_SYMBOL) begin
                // only the opening column and the one after it are charged
                if (!in_gap) begin
                    in_gap            = 1'b1;
                    extension_charged = 1'b0;
                    accumulate(gap_weight);
                end else if (!extension_charged) begin
                    extension_charged = 1'b1;
                    accumulate(gap_weight);
                end
            end else begin
                in_gap = 1'b0;
                if (t != q) begin
                    accumulate(mismatch_weight);
                end else begin
                    case (classify(t))
                        acs_pkg::BC_AT: accumulate(at_weight);
                        acs_pkg::BC_GC: accumulate(gc_weight);
                        default: ;
                    endcase
                end
            end
            if (last) begin
                wide            = running;
                entry.score     = wide[acs_pkg::OUT_WIDTH-1:0];
                entry.saturated = clamped;
                expected_scores.push_back(entry);
                clear_alignment();
            end
        endfunction

        function void check_result(logic signed [acs_pkg::OUT_WIDTH-1:0] score,
                                   logic saturated);
            final_score_t want;
            if (expected_scores.size() == 0) begin
                $error("score item %0d arrived with no alignment outstanding", score);
                failures++;
                return;
            end
            want = expected_scores.pop_front();
            if (score !== want.score) begin
                $error("alignment_score: expected %0d, got %0d", want.score, score);
                failures++;
            end
            if (saturated !== want.saturated) begin
                $error("score_saturated: expected %0b, got %0b", want.saturated, saturated);
                failures++;
            end
        endfunction

        function int outstanding();
            return expected_scores.size();
        endfunction
    endclass

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #6 aclk = ~aclk;

    // every block input starts at a known value
    logic                                 cfg_wr_en       = 1'b0;
    logic [1:0]                           cfg_index       = '0;
    logic [acs_pkg::COST_WIDTH-1:0]       cfg_data        = '0;
    logic                                 s_valid         = 1'b0;
    logic                                 s_ready;
    logic [acs_pkg::SYM_WIDTH-1:0]        s_target_symbol = '0;
    logic [acs_pkg::SYM_WIDTH-1:0]        s_query_symbol  = '0;
    logic                                 s_last_column   = 1'b0;
    logic                                 m_valid;
    logic                                 m_ready         = 1'b0;
    logic signed [acs_pkg::OUT_WIDTH-1:0] m_alignment_score;
    logic                                 m_score_saturated;

    // pulse from the stimulus side that starts a long receiver hold-off
    logic hold_start = 1'b0;

    alignment_column_scorer DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_target_symbol   (s_target_symbol),
        .s_query_symbol    (s_query_symbol),
        .s_last_column     (s_last_column),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_alignment_score (m_alignment_score),
        .m_score_saturated (m_score_saturated)
    );

    alignment_tally tally;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int column_count  = 0;

    // receiver: handshakes are judged on the values seen just before the edge,
    // then ready for the next cycle is chosen; a hold-off forces ready low
    int hold_left = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tally.check_result(m_alignment_score, m_score_saturated);
        end
        if (hold_start) begin
            hold_left = 300;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one column item; valid is only lowered when the sender actually idles,
    // so back-to-back items never see valid dropped and raised in one step
    task automatic send_column(input logic [acs_pkg::SYM_WIDTH-1:0] t,
                               input logic [acs_pkg::SYM_WIDTH-1:0] q,
                               input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_target_symbol <= t;
        s_query_symbol  <= q;
        s_last_column   <= last;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge
        tally.note_column(t, q, last);
        column_count++;
    endtask

    // sender stops until every score has come back, then lets the pipe settle
    task automatic wait_for_scores();
        s_valid <= 1'b0;
        while (tally.outstanding() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // writes all four weights, only ever called with the block idle
    task automatic load_weights(input logic [acs_pkg::COST_WIDTH-1:0] at_w,
                                input logic [acs_pkg::COST_WIDTH-1:0] gc_w,
                                input logic [acs_pkg::COST_WIDTH-1:0] mm_w,
                                input logic [acs_pkg::COST_WIDTH-1:0] gap_w);
        acs_pkg::cfg_index_t order [4] = '{acs_pkg::CFG_AT_MATCH, acs_pkg::CFG_GC_MATCH,
                                           acs_pkg::CFG_MISMATCH, acs_pkg::CFG_GAP_COST};
        logic [acs_pkg::COST_WIDTH-1:0] values [4];
        values = '{at_w, gc_w, mm_w, gap_w};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= values[i];
            tally.set_weight(order[i], values[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_random_weights();
        int unsigned raw [4];
        foreach (raw[i]) raw[i] = $urandom_range(255);
        load_weights(raw[0][acs_pkg::COST_WIDTH-1:0], raw[1][acs_pkg::COST_WIDTH-1:0],
                     raw[2][acs_pkg::COST_WIDTH-1:0], raw[3][acs_pkg::COST_WIDTH-1:0]);
    endtask

    // bases most often, with gaps, ambiguity codes and arbitrary bytes mixed in
    function automatic logic [acs_pkg::SYM_WIDTH-1:0] pick_symbol();
        string nucleotides = "ACGTUacgtu";
        int    roll;
        roll = $urandom_range(99);
        if (roll < 45) return nucleotides[$urandom_range(9)];
        if (roll < 60) return acs_pkg::GAP_SYMBOL;
        if (roll < 70) return ($urandom_range(1) == 1) ? "N" : "n";
        roll = $urandom_range(255);
        return roll[acs_pkg::SYM_WIDTH-1:0];
    endfunction

    // one well-formed alignment: random content, about half the columns identical,
    // with occasional gap runs long enough to pass the two charged columns
    task automatic send_random_alignment(input int max_len);
        int                            len;
        int                            gap_left;
        logic [acs_pkg::SYM_WIDTH-1:0] t;
        logic [acs_pkg::SYM_WIDTH-1:0] q;
        len      = $urandom_range(max_len, 1);
        gap_left = 0;
        for (int i = 0; i < len; i++) begin
            t = pick_symbol();
            q = ($urandom_range(1) == 1) ? t : pick_symbol();
            if (gap_left == 0 && $urandom_range(7) == 0) gap_left = $urandom_range(5, 1);
            if (gap_left > 0) begin
                gap_left--;
                case ($urandom_range(2))
                    0:       t = acs_pkg::GAP_SYMBOL;
                    1:       q = acs_pkg::GAP_SYMBOL;
                    default: begin
                        t = acs_pkg::GAP_SYMBOL;
                        q = acs_pkg::GAP_SYMBOL;
                    end
                endcase
            end
            send_column(t, q, i == len - 1);
        end
    endtask

    task automatic run_random(input int columns, input int max_len);
        int target;
        target = column_count + columns;
        while (column_count < target) send_random_alignment(max_len);
    endtask

    initial begin
        tally         = new();
        send_idle_pct = 35;
        recv_idle_pct = 65;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed columns with the reset weights
        send_column("A", "A", 1'b0);
        send_column("t", "t", 1'b0);
        send_column("U", "u", 1'b0);    // raw byte compare, case differs: mismatch
        send_column("u", "u", 1'b0);    // u scores as t
        send_column("G", "G", 1'b0);
        send_column("c", "c", 1'b0);
        send_column("a", "A", 1'b0);
        send_column("N", "N", 1'b0);    // identical non-base adds nothing
        send_column(8'h00, 8'h00, 1'b0);
        send_column(8'hFF, 8'hFF, 1'b0);
        send_column(8'h00, 8'hFF, 1'b0);
        send_column(acs_pkg::GAP_SYMBOL, "A", 1'b0);
        send_column("C", acs_pkg::GAP_SYMBOL, 1'b0);
        // third gap column is free
        send_column(acs_pkg::GAP_SYMBOL, acs_pkg::GAP_SYMBOL, 1'b0);
        send_column("G", "G", 1'b0);                          // ends the gap run
        send_column(acs_pkg::GAP_SYMBOL, "T", 1'b1);          // fresh run on the last column
        // alignment of a single gap
        send_column(acs_pkg::GAP_SYMBOL, acs_pkg::GAP_SYMBOL, 1'b1);
        send_column("T", "C", 1'b1);
        // a gap column opening an alignment, then a gap run before its last column
        send_column(acs_pkg::GAP_SYMBOL, "g", 1'b0);
        send_column("A", "A", 1'b0);
        send_column(acs_pkg::GAP_SYMBOL, acs_pkg::GAP_SYMBOL, 1'b0);
        send_column(acs_pkg::GAP_SYMBOL, acs_pkg::GAP_SYMBOL, 1'b0);
        send_column(acs_pkg::GAP_SYMBOL, acs_pkg::GAP_SYMBOL, 1'b0);
        send_column("C", "C", 1'b1);
        wait_for_scores();

        // first idling pattern: extreme weights, then random ones
        load_weights(8'sd127, -8'sd128, 8'sd127, -8'sd128);
        run_random(50, 12);
        wait_for_scores();
        load_random_weights();
        run_random(100, 12);
        wait_for_scores();

        // second idling pattern: the opposite extremes, all zero, then random
        send_idle_pct = 65;
        recv_idle_pct = 35;
        load_weights(-8'sd128, 8'sd127, -8'sd128, 8'sd127);
        run_random(50, 12);
        wait_for_scores();
        load_weights(8'sd0, 8'sd0, 8'sd0, 8'sd0);
        run_random(30, 8);
        wait_for_scores();
        load_random_weights();
        run_random(70, 12);
        wait_for_scores();

        // back-pressure: receiver holds off while short alignments keep coming,
        // so scores pile up and the input stalls
        send_idle_pct = 0;
        load_random_weights();
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        repeat (40) send_random_alignment(2);
        wait_for_scores();

        // no idling on either side
        recv_idle_pct = 0;
        load_random_weights();
        run_random(140, 12);
        wait_for_scores();

        if (tally.failures == 0 && tally.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/acs_pkg.sv
hw/rtl/acs_column_delta.sv
hw/rtl/acs_accum.sv
hw/rtl/alignment_column_scorer.sv
bench/testbench.sv
